// ===== hw/rtl/char_lcd_4bit_bus_emulator_macros.svh =====
// Assertion macros shared by the character LCD bus emulator RTL.
`ifndef CHAR_LCD_4BIT_BUS_EMULATOR_MACROS_SVH
`define CHAR_LCD_4BIT_BUS_EMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLBE_ASSERT_IMP(lbl, clk, rstn, pre, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLBE_ASSERT_NXT(lbl, clk, rstn, pre, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/clbe_pkg.sv =====
// Package: constants and types of the character LCD 4-bit bus emulator.
package clbe_pkg;

  // Expander port byte bit positions
  localparam int unsigned BitBl = 3;
  localparam int unsigned BitEn = 2;
  localparam int unsigned BitRw = 1;
  localparam int unsigned BitRs = 0;

  // Configuration register indexes
  localparam logic [0:0] CfgRowCount    = 1'b0;
  localparam logic [0:0] CfgColumnCount = 1'b1;

  localparam int unsigned CfgWidth = 6;

  // Reset values
  localparam logic [2:0] RowCountReset    = 3'd4;
  localparam logic [5:0] ColumnCountReset = 6'd20;
  localparam int unsigned MaxColumnsDefault = 40;

  // Address map of the display RAM
  localparam logic [6:0] AddrWrap     = 7'h68;
  localparam logic [6:0] AddrGapLo    = 7'h28;
  localparam logic [6:0] AddrGapHi    = 7'h3f;
  localparam logic [6:0] AddrLine2    = 7'h40;
  localparam logic [5:0] FoldColumn   = 6'd20;
  localparam logic [2:0] FoldRowCount = 3'd4;

  // Accumulator holds a marker bit above the collected nibbles
  localparam logic [8:0] AccEmpty = 9'h001;

  localparam int unsigned OutDataWidth = 32;

  typedef struct packed {
    logic [5:0] columns_in_use;
    logic       display_on;
    logic       clear_screen;
    logic [7:0] char_code;
    logic [5:0] char_col;
    logic [1:0] char_row;
    logic       char_write;
  } clbe_result_t;

endpackage

// ===== hw/rtl/char_lcd_4bit_bus_emulator.sv =====
// Top level: character LCD 4-bit bus emulator decoding expander port beats.
//
// Channel   Dir  Fields (tdata, lowest bit up)
// s_axis    in   port_byte[7:0]
// m_axis    out  char_write, char_row[1:0], char_col[5:0], char_code[7:0],
//                clear_screen, display_on, columns_in_use[5:0], zero pad to 32
// cfg       in   index 0 row_count[2:0], index 1 column_count[5:0]
//
// One result beat per input beat, in the cycle after acceptance; a beat every cycle unless m_axis stalls.
// The decode runs in one pass from the state registers into the output register.
// Reset (async, active low) restores the register defaults and empties the
// nibble accumulator. While m_axis stalls, the output register holds and a new
// beat is taken only when the output register is empty or being drained.
module char_lcd_4bit_bus_emulator
  import clbe_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [CfgWidth-1:0]     cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,  // port_byte[7:0]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // char_write, char_row[1:0], char_col[5:0], char_code[7:0], clear_screen,
  // display_on, columns_in_use[5:0], zero pad
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  localparam logic [6:0] MaxCol = 7'(MAX_COLUMNS);

  logic [2:0]   row_count_q;
  logic [8:0]   acc_q, acc_d;
  logic         sel_q, sel_d;
  logic [6:0]   addr_q, addr_d;
  logic [5:0]   track_q, track_d;
  logic         light_q, light_d;
  logic         out_valid_q;
  clbe_result_t res_q, res_d;

  logic         accept;
  logic         strobe;
  logic         sel_in;
  logic [8:0]   acc_shift;
  logic [7:0]   byte_val;
  logic [6:0]   addr_fix;
  logic [5:0]   col;
  logic [1:0]   row;
  logic [6:0]   col_inc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign strobe        = s_axis_tdata[BitEn] && !s_axis_tdata[BitRw];
  assign sel_in        = s_axis_tdata[BitRs];

  // Restart pairing on a register select change, then shift the nibble in
  assign acc_shift = {((sel_in != sel_q) ? AccEmpty[4:0] : acc_q[4:0]),
                      s_axis_tdata[7:4]};
  assign byte_val  = acc_shift[7:0];

  // Map the current address onto the visible lines
  always_comb begin
    addr_fix = addr_q;
    if (addr_q >= AddrWrap) begin
      addr_fix = '0;
    end else if (addr_q inside {[AddrGapLo:AddrGapHi]}) begin
      addr_fix = AddrLine2;
    end
    col = addr_fix[5:0];
    row = {1'b0, addr_fix[6]};
    if (row_count_q == FoldRowCount && col >= FoldColumn) begin
      col = col - FoldColumn;
      row = row + 2'd2;
    end
    col_inc = {1'b0, col} + 7'd1;
  end

  always_comb begin
    acc_d   = acc_q;
    sel_d   = sel_q;
    addr_d  = addr_q;
    track_d = track_q;
    light_d = light_q;
    res_d   = '0;
    if (strobe) begin
      light_d = s_axis_tdata[BitBl];
      sel_d   = sel_in;
      acc_d   = acc_shift;
      if (acc_shift[8]) begin
        acc_d = AccEmpty;
        if (sel_in) begin
          res_d.char_write = 1'b1;
          res_d.char_row   = row;
          res_d.char_col   = col;
          res_d.char_code  = byte_val;
          addr_d           = addr_fix + 7'd1;
          if (col >= track_q) begin
            track_d = (col_inc > MaxCol) ? MaxCol[5:0] : col_inc[5:0];
          end
        end else begin
          case (1'b1)
            byte_val[7]:          addr_d = byte_val[6:0];
            (byte_val >= 8'h04):  addr_d = addr_q;
            (byte_val >= 8'h02):  addr_d = '0;
            (byte_val == 8'h01): begin
              addr_d             = '0;
              res_d.clear_screen = 1'b1;
            end
            default:              addr_d = addr_q;
          endcase
        end
      end
    end
    res_d.display_on     = light_d;
    res_d.columns_in_use = track_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountReset;
      acc_q       <= AccEmpty;
      sel_q       <= 1'b0;
      addr_q      <= '0;
      track_q     <= ColumnCountReset;
      light_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_q   <= acc_d;
        sel_q   <= sel_d;
        addr_q  <= addr_d;
        track_q <= track_d;
        light_q <= light_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRowCount:    row_count_q <= cfg_wdata_i[2:0];
          CfgColumnCount: track_q     <= cfg_wdata_i;
          default:        row_count_q <= row_count_q;
        endcase
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload register: load on each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth - $bits(clbe_result_t)){1'b0}}, res_q};

`include "char_lcd_4bit_bus_emulator_macros.svh"

  `CLBE_ASSERT_IMP(a_write_xor_clear, clk_i, rst_ni, out_valid_q, !(res_q.char_write && res_q.clear_screen), "write and clear in one beat")
  `CLBE_ASSERT_IMP(a_col_range, clk_i, rst_ni, out_valid_q && res_q.char_write, res_q.char_col < 6'd40, "written column out of range")
  `CLBE_ASSERT_NXT(a_no_strobe_quiet, clk_i, rst_ni, accept && !strobe, !res_q.char_write && !res_q.clear_screen, "unstrobed beat produced an action")
  `CLBE_ASSERT_IMP(a_stall_full, clk_i, rst_ni, !s_axis_tready, out_valid_q && !m_axis_tready, "input stalled without a pending result")

endmodule
